>>> hdl/input_jitter_reorder_buffer_defines.svh
// Assertion macros used by the checker file ijrb_checker.sv.
`ifndef INPUT_JITTER_REORDER_BUFFER_DEFINES_SVH
`define INPUT_JITTER_REORDER_BUFFER_DEFINES_SVH

// Implication check, disabled during reset.
`define IJRB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ijrb check failed");

// Next-cycle implication check, disabled during reset.
`define IJRB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ijrb check failed");

`endif

>>> hdl/ijrb_pkg.sv
package ijrb_pkg;
   localparam int Capacity   = 16;
   localparam int IdxW       = $clog2(Capacity);
   localparam int FillW      = $clog2(Capacity + 1);
   localparam int MaxActions = 8;
   localparam int ActLim     = (MaxActions < 8) ? MaxActions : 8;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_BELOW    = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_EVICT    = 3'd3;
   localparam logic [2:0] ST_DELIVER  = 3'd4;
   localparam logic [2:0] ST_STARVED  = 3'd5;
   localparam logic [2:0] ST_NOINPUT  = 3'd6;

   localparam logic KIND_INSERT = 1'b0;

   localparam logic CSR_TARGET_DEPTH    = 1'b0;
   localparam logic CSR_COLLAPSE_STREAK = 1'b1;

   typedef struct packed {
      logic [63:0] tick;
      logic [3:0]  count;
      logic [31:0] flags;
      logic [31:0] tag;
   } rec_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DUP_RD, S_DUP_CMP, S_SORT_RD, S_SORT_CMP, S_SORT_WR_FIX, S_POP_RD,
      S_POP_GET, S_COL_RD, S_COL_GET, S_FINISH, S_OUT
   } state_type;

   function automatic logic [31:0] carry_edges(rec_type older, rec_type newer);
      logic [3:0]  n;
      logic [31:0] f;
      n = (older.count < newer.count) ? older.count : newer.count;
      f = newer.flags;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < n) f[4*i +: 4] = f[4*i +: 4] | (older.flags[4*i +: 4] & 4'hE);
      end
      return f;
   endfunction

   function automatic logic [31:0] clear_edges(rec_type r);
      logic [31:0] f;
      logic [3:0]  nib;
      f = r.flags;
      for (int i = 0; i < 8; i++) begin
         nib = f[4*i +: 4];
         if (4'(i) < r.count) f[4*i +: 4] = nib[0] ? {nib[3], 3'b001} : 4'h0;
      end
      return f;
   endfunction
endpackage

>>> hdl/input_jitter_reorder_buffer.sv
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid / req_ready   | kind, tick, command_newest_tick, actions, tag
// rsp     | out       | rsp_valid / rsp_ready   | status, record, shed_count, starved_total
// csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
// One item at a time: one comparator walks the slot memory, one entry per step.
// Insert: a duplicate scan over the filled region, then sort swap steps (read, compare,
// write fix) that walk the new record down; consume: pop read and get, then finish, with
// a collapse read and get per collapsed record when a collapse runs.
// Reset is synchronous and clears control state; the slot memory keeps no reset.
// The result is held in an output register until taken; req_ready stays low meanwhile.
module input_jitter_reorder_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [63:0] req_tick,
   input  logic [63:0] req_command_newest_tick,
   input  logic [3:0]  req_action_count,
   input  logic [31:0] req_action_flags,
   input  logic [31:0] req_payload_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_out_tick,
   output logic [3:0]  rsp_out_action_count,
   output logic [31:0] rsp_out_action_flags,
   output logic [31:0] rsp_out_payload_tag,
   output logic [3:0]  rsp_shed_count,
   output logic [31:0] rsp_starved_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   localparam int IW = ijrb_pkg::IdxW;
   localparam int FW = ijrb_pkg::FillW;

   // slot memory: one write port, one registered read port
   ijrb_pkg::rec_type mem [ijrb_pkg::Capacity];
   ijrb_pkg::rec_type rd_ff;
   logic [IW-1:0]     rd_addr;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   ijrb_pkg::rec_type wr_data;

   ijrb_pkg::state_type state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] pos_ff, pos_in;       // walk position (offset from head)
   logic [7:0]    streak_ff, streak_in;
   logic [63:0]   floor_ff, floor_in;
   logic          seen_ff, seen_in;
   logic          have_ff, have_in;
   logic [31:0]   starve_ff, starve_in;
   logic [4:0]    target_ff;
   logic [7:0]    collapse_ff;
   ijrb_pkg::rec_type new_ff, new_in;   // record being inserted
   ijrb_pkg::rec_type cur_ff, cur_in;   // record being delivered / last record
   ijrb_pkg::rec_type last_ff, last_in;
   logic [2:0]    status_ff, status_in;
   logic [3:0]    shed_ff, shed_in;
   logic          out_rec_ff, out_rec_in; // drive record fields

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ijrb_pkg::S_IDLE);
   assign rsp_valid = (state_ff == ijrb_pkg::S_OUT);
   assign rsp_status = status_ff;
   assign rsp_out_tick = out_rec_ff ? cur_ff.tick : 64'd0;
   assign rsp_out_action_count = out_rec_ff ? cur_ff.count : 4'd0;
   assign rsp_out_action_flags = out_rec_ff ? cur_ff.flags : 32'd0;
   assign rsp_out_payload_tag = out_rec_ff ? cur_ff.tag : 32'd0;
   assign rsp_shed_count = shed_ff;
   assign rsp_starved_total = starve_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ijrb_pkg::S_IDLE;
         head_ff <= '0; fill_ff <= '0; pos_ff <= '0; streak_ff <= '0;
         floor_ff <= '0; seen_ff <= 1'b0; have_ff <= 1'b0; starve_ff <= '0;
         target_ff <= 5'd2; collapse_ff <= 8'd4;
         last_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; fill_ff <= fill_in; pos_ff <= pos_in;
         streak_ff <= streak_in; floor_ff <= floor_in; seen_ff <= seen_in;
         have_ff <= have_in; starve_ff <= starve_in; last_ff <= last_in;
         if (csr_valid) begin
            if (csr_index == ijrb_pkg::CSR_TARGET_DEPTH) target_ff <= csr_data[4:0];
            else collapse_ff <= csr_data;
         end
      end
      new_ff <= new_in; cur_ff <= cur_in; status_ff <= status_in;
      shed_ff <= shed_in; out_rec_ff <= out_rec_in;
   end

   // offset from head to physical slot (capacity is a power of two)
   function automatic logic [IW-1:0] slot(logic [IW-1:0] h, logic [FW-1:0] o);
      return h + o[IW-1:0];
   endfunction

   always_comb begin
      ijrb_pkg::rec_type nw;
      logic [3:0] cnt;
      state_in = state_ff; head_in = head_ff; fill_in = fill_ff; pos_in = pos_ff;
      streak_in = streak_ff; floor_in = floor_ff; seen_in = seen_ff;
      have_in = have_ff; starve_in = starve_ff; last_in = last_ff;
      new_in = new_ff; cur_in = cur_ff; status_in = status_ff; shed_in = shed_ff;
      out_rec_in = out_rec_ff;
      rd_addr = slot(head_ff, pos_ff);
      wr_en = 1'b0; wr_addr = slot(head_ff, pos_ff); wr_data = new_ff;
      nw = rd_ff;
      cnt = (req_action_count > 4'(ijrb_pkg::ActLim)) ? 4'(ijrb_pkg::ActLim)
                                                       : req_action_count;
      unique case (state_ff)
         ijrb_pkg::S_IDLE: begin
            if (req_valid) begin
               shed_in = '0; out_rec_in = 1'b0;
               if (req_kind == ijrb_pkg::KIND_INSERT) begin
                  new_in = '{req_tick, cnt, req_action_flags, req_payload_tag};
                  status_in = ijrb_pkg::ST_INSERTED;
                  seen_in = 1'b1;
                  floor_in = seen_ff ? floor_ff : req_command_newest_tick;
                  pos_in = '0;
                  if (req_tick < (seen_ff ? floor_ff : req_command_newest_tick)) begin
                     status_in = ijrb_pkg::ST_BELOW;
                     state_in = ijrb_pkg::S_OUT;
                  end else state_in = ijrb_pkg::S_DUP_RD;
               end else if (fill_ff != '0) begin
                  pos_in = '0;
                  state_in = ijrb_pkg::S_POP_RD;
               end else if (!have_ff) begin
                  status_in = ijrb_pkg::ST_NOINPUT;
                  state_in = ijrb_pkg::S_OUT;
               end else begin
                  streak_in = '0;
                  if (starve_ff != '1) starve_in = starve_ff + 32'd1;
                  last_in.flags = ijrb_pkg::clear_edges(last_ff);
                  cur_in = last_ff;
                  cur_in.flags = ijrb_pkg::clear_edges(last_ff);
                  out_rec_in = 1'b1;
                  status_in = ijrb_pkg::ST_STARVED;
                  state_in = ijrb_pkg::S_OUT;
               end
            end
         end
         // duplicate scan over the filled region
         ijrb_pkg::S_DUP_RD: begin
            if (pos_ff >= fill_ff) begin
               if (fill_ff >= FW'(ijrb_pkg::Capacity)) begin
                  head_in = head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
                  status_in = ijrb_pkg::ST_EVICT;
                  // append in the evicted head slot, which is new head + fill-1
                  wr_en = 1'b1;
                  wr_addr = head_ff;
                  pos_in = fill_ff - 1'b1;
                  fill_in = fill_ff;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = slot(head_ff, fill_ff);
                  pos_in = fill_ff;
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ijrb_pkg::S_SORT_RD;
            end else state_in = ijrb_pkg::S_DUP_CMP;
         end
         ijrb_pkg::S_DUP_CMP: begin
            if (rd_ff.tick == new_ff.tick) begin
               status_in = ijrb_pkg::ST_DUP;
               state_in = ijrb_pkg::S_OUT;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = ijrb_pkg::S_DUP_RD;
            end
         end
         // new record sits at pos; read its predecessor
         ijrb_pkg::S_SORT_RD: begin
            rd_addr = slot(head_ff, pos_ff - 1'b1);
            if (pos_ff == '0) state_in = ijrb_pkg::S_OUT;
            else state_in = ijrb_pkg::S_SORT_CMP;
         end
         ijrb_pkg::S_SORT_CMP: begin
            if (rd_ff.tick <= new_ff.tick) state_in = ijrb_pkg::S_OUT;
            else begin
               // shift predecessor up; new record moves down
               wr_en = 1'b1;
               wr_data = rd_ff;
               pos_in = pos_ff - 1'b1;
               state_in = ijrb_pkg::S_SORT_WR_FIX;
            end
         end
         ijrb_pkg::S_POP_RD: begin
            rd_addr = head_ff;
            state_in = ijrb_pkg::S_POP_GET;
         end
         ijrb_pkg::S_POP_GET: begin
            cur_in = rd_ff;
            head_in = head_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
            if ({1'b0, fill_ff - 1'b1} > {{(FW-4){1'b0}}, target_ff}) begin
               if (streak_ff != 8'hFF) streak_in = streak_ff + 8'd1;
               if (((streak_ff != 8'hFF) ? streak_ff + 8'd1 : streak_ff) >= collapse_ff)
                  state_in = ijrb_pkg::S_COL_RD;
               else state_in = ijrb_pkg::S_FINISH;
            end else begin
               streak_in = '0;
               state_in = ijrb_pkg::S_FINISH;
            end
         end
         ijrb_pkg::S_COL_RD: begin
            rd_addr = head_ff;
            if ({1'b0, fill_ff} > {{(FW-4){1'b0}}, target_ff}) state_in = ijrb_pkg::S_COL_GET;
            else begin
               streak_in = '0;
               state_in = ijrb_pkg::S_FINISH;
            end
         end
         ijrb_pkg::S_COL_GET: begin
            nw.flags = ijrb_pkg::carry_edges(cur_ff, rd_ff);
            cur_in = nw;
            head_in = head_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
            if (shed_ff != 4'hF) shed_in = shed_ff + 4'd1;
            state_in = ijrb_pkg::S_COL_RD;
         end
         ijrb_pkg::S_FINISH: begin
            last_in = cur_ff;
            have_in = 1'b1;
            floor_in = (cur_ff.tick == '1) ? cur_ff.tick : cur_ff.tick + 64'd1;
            out_rec_in = 1'b1;
            status_in = ijrb_pkg::ST_DELIVER;
            state_in = ijrb_pkg::S_OUT;
         end
         ijrb_pkg::S_SORT_WR_FIX: begin
            // place new record at its lower slot, then keep walking
            wr_en = 1'b1;
            wr_data = new_ff;
            state_in = ijrb_pkg::S_SORT_RD;
         end
         ijrb_pkg::S_OUT: begin
            if (rsp_ready) state_in = ijrb_pkg::S_IDLE;
         end
         default: state_in = ijrb_pkg::S_IDLE;
      endcase
   end
endmodule

>>> hdl/ijrb_checker.sv
`include "input_jitter_reorder_buffer_defines.svh"
module ijrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_shed_count
);
   `IJRB_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `IJRB_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `IJRB_ASSERT_IMP(a_status_legal, clock, reset, rsp_valid, rsp_status != 3'd7)
   `IJRB_ASSERT_IMP(a_shed_only_deliver, clock, reset, rsp_valid && rsp_shed_count != 4'd0,
      rsp_status == ijrb_pkg::ST_DELIVER)
   `IJRB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status))
endmodule

bind input_jitter_reorder_buffer ijrb_checker u_ijrb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_shed_count(rsp_shed_count)
);
